// ===== hw/rtl/afr_pkg.sv =====
// ----------------------------------------------------------------------------
// afr_pkg: shared constants and tables for the aspect field-of-view rescaler
// Angle formats, default pipeline parameters and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package afr_pkg;

    localparam int DEF_CORDIC_STEPS = 20;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int FOV_W  = 24;
    localparam int DIM_W  = 16;
    localparam int ANG_W  = 34;
    localparam int MUL_W  = DIM_W + 2;

    localparam logic [FOV_W-1:0]        FOV_180   = 24'd11796480;
    localparam logic signed [ANG_W-1:0] ANG_90    = 34'sd1509949440;
    localparam logic signed [ANG_W-1:0] ANG_ROUND = 34'sd64;

    localparam logic CMD_FORWARD = 1'b0;
    localparam logic CMD_INVERSE = 1'b1;

    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            5'd0:  v = 34'sd754974720;
            5'd1:  v = 34'sd445687602;
            5'd2:  v = 34'sd235489088;
            5'd3:  v = 34'sd119537938;
            5'd4:  v = 34'sd60000934;
            5'd5:  v = 34'sd30029717;
            5'd6:  v = 34'sd15018523;
            5'd7:  v = 34'sd7509720;
            5'd8:  v = 34'sd3754917;
            5'd9:  v = 34'sd1877466;
            5'd10: v = 34'sd938734;
            5'd11: v = 34'sd469367;
            5'd12: v = 34'sd234684;
            5'd13: v = 34'sd117342;
            5'd14: v = 34'sd58671;
            5'd15: v = 34'sd29335;
            5'd16: v = 34'sd14668;
            5'd17: v = 34'sd7334;
            5'd18: v = 34'sd3667;
            5'd19: v = 34'sd1833;
            5'd20: v = 34'sd917;
            5'd21: v = 34'sd458;
            5'd22: v = 34'sd229;
            5'd23: v = 34'sd115;
            5'd24: v = 34'sd57;
            5'd25: v = 34'sd29;
            5'd26: v = 34'sd14;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd4;
            5'd29: v = 34'sd2;
            5'd30: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aspect_fov_rescale_unit.sv =====
// ----------------------------------------------------------------------------
// aspect_fov_rescale_unit: aspect-ratio field-of-view rescaler
// Rotation CORDIC for the half angle, one multiply stage, vectoring CORDIC.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge with start high and busy low; busy
// is held low, so one beat may be taken in every cycle. Each beat carries the
// direction, the screen width and height and the input angle in Q8.16 degrees.
// The result appears on o_fov_out for one cycle with o_strobe high, once its
// command beat has passed through one input stage, CORDIC_STEPS rotation
// stages, one multiply stage, CORDIC_STEPS vectoring stages and one output
// stage. Throughput is one beat per cycle,
// set by the fully pipelined CORDIC stages.
// The mode register is written through i_cfg_valid and o_cfg_ready, which is
// always high; it should only be written while no beat is in flight.
// Reset clears every valid bit in the pipeline and sets the mode to scaling.
// The receiver cannot stall: each result must be taken in its strobe cycle.
`default_nettype none

module aspect_fov_rescale_unit #(
    parameter int CORDIC_STEPS = afr_pkg::DEF_CORDIC_STEPS,
    parameter int FRAC_BITS    = afr_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_command,
    input  wire logic [afr_pkg::DIM_W-1:0]   i_screen_width,
    input  wire logic [afr_pkg::DIM_W-1:0]   i_screen_height,
    input  wire logic [afr_pkg::FOV_W-1:0]   i_fov_in,
    output logic                             o_strobe,
    output logic [afr_pkg::FOV_W-1:0]        o_fov_out,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_data
);
    import afr_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int RW = FRAC_BITS + 4;
    localparam int CW = FRAC_BITS + 2;
    localparam int PW = CW + MUL_W;
    localparam int VW = PW + 3;

    logic r_mode;

    // Rotation section.
    logic                    r_rv   [0:N];
    logic                    r_rbyp [0:N];
    logic [FOV_W-1:0]        r_rval [0:N];
    logic                    r_rinv [0:N];
    logic [DIM_W-1:0]        r_rw   [0:N];
    logic [DIM_W-1:0]        r_rh   [0:N];
    logic signed [RW-1:0]    r_rx   [0:N];
    logic signed [RW-1:0]    r_ry   [0:N];
    logic signed [ANG_W-1:0] r_rz   [0:N];

    // Vectoring section.
    logic                    r_vv   [0:N];
    logic                    r_vbyp [0:N];
    logic [FOV_W-1:0]        r_vval [0:N];
    logic signed [VW-1:0]    r_vx   [0:N];
    logic signed [VW-1:0]    r_vy   [0:N];
    logic signed [ANG_W-1:0] r_vz   [0:N];

    logic                    n_byp;
    logic [FOV_W-1:0]        n_val;

    logic [CW-1:0]           n_c;
    logic [CW-1:0]           n_s;
    logic [MUL_W-1:0]        n_w3;
    logic [MUL_W-1:0]        n_h4;
    logic [PW-1:0]           n_px;
    logic [PW-1:0]           n_py;

    logic signed [ANG_W-1:0] n_zc;
    logic signed [ANG_W-1:0] n_zr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    always_comb begin
        n_byp = 1'b1;
        n_val = i_fov_in;
        if (r_mode && (i_screen_height != '0)) begin
            if (i_fov_in >= FOV_180) begin
                n_val = FOV_180;
            end else if (i_screen_width == '0) begin
                n_val = (i_command == CMD_INVERSE) ? FOV_180 : '0;
            end else begin
                n_byp = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else begin
            r_rv[0] <= start && !busy;
        end
        r_rbyp[0] <= n_byp;
        r_rval[0] <= n_val;
        r_rinv[0] <= i_command;
        r_rw[0]   <= i_screen_width;
        r_rh[0]   <= i_screen_height;
        r_rx[0]   <= RW'(1) <<< FRAC_BITS;
        r_ry[0]   <= '0;
        r_rz[0]   <= ANG_W'({i_fov_in, 7'b0});
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[k+1] <= 1'b0;
            end else begin
                r_rv[k+1] <= r_rv[k];
            end
            r_rbyp[k+1] <= r_rbyp[k];
            r_rval[k+1] <= r_rval[k];
            r_rinv[k+1] <= r_rinv[k];
            r_rw[k+1]   <= r_rw[k];
            r_rh[k+1]   <= r_rh[k];
            if (r_rz[k] >= 0) begin
                r_rx[k+1] <= r_rx[k] - (r_ry[k] >>> k);
                r_ry[k+1] <= r_ry[k] + (r_rx[k] >>> k);
                r_rz[k+1] <= r_rz[k] - atan_deg(5'(k));
            end else begin
                r_rx[k+1] <= r_rx[k] + (r_ry[k] >>> k);
                r_ry[k+1] <= r_ry[k] - (r_rx[k] >>> k);
                r_rz[k+1] <= r_rz[k] + atan_deg(5'(k));
            end
        end
    end

    always_comb begin
        n_c  = r_rx[N][RW-1] ? '0 : r_rx[N][CW-1:0];
        n_s  = r_ry[N][RW-1] ? '0 : r_ry[N][CW-1:0];
        n_w3 = {2'b00, r_rw[N]} + {1'b0, r_rw[N], 1'b0};
        n_h4 = {r_rh[N], 2'b00};
        if (r_rinv[N] == CMD_INVERSE) begin
            n_py = PW'(n_h4 * n_s);
            n_px = PW'(n_w3 * n_c);
        end else begin
            n_py = PW'(n_w3 * n_s);
            n_px = PW'(n_h4 * n_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv[0] <= 1'b0;
        end else begin
            r_vv[0] <= r_rv[N];
        end
        r_vbyp[0] <= r_rbyp[N];
        r_vval[0] <= r_rval[N];
        r_vx[0]   <= VW'(n_px);
        r_vy[0]   <= VW'(n_py);
        r_vz[0]   <= '0;
    end

    for (genvar j = 0; j < N; j++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vv[j+1] <= 1'b0;
            end else begin
                r_vv[j+1] <= r_vv[j];
            end
            r_vbyp[j+1] <= r_vbyp[j];
            r_vval[j+1] <= r_vval[j];
            if (r_vy[j] > 0) begin
                r_vx[j+1] <= r_vx[j] + (r_vy[j] >>> j);
                r_vy[j+1] <= r_vy[j] - (r_vx[j] >>> j);
                r_vz[j+1] <= r_vz[j] + atan_deg(5'(j));
            end else begin
                r_vx[j+1] <= r_vx[j] - (r_vy[j] >>> j);
                r_vy[j+1] <= r_vy[j] + (r_vx[j] >>> j);
                r_vz[j+1] <= r_vz[j] - atan_deg(5'(j));
            end
        end
    end

    always_comb begin
        n_zc = r_vz[N];
        if (n_zc < 0) begin
            n_zc = '0;
        end else if (n_zc > ANG_90) begin
            n_zc = ANG_90;
        end
        n_zr = n_zc + ANG_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_vv[N];
        end
        o_fov_out <= r_vbyp[N] ? r_vval[N] : n_zr[30:7];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/afr_checker.sv =====
// ----------------------------------------------------------------------------
// afr_checker: port-level checks for the aspect field-of-view rescaler
// Watches latency, range and handshake behaviour on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module afr_checker #(
    parameter int CORDIC_STEPS = afr_pkg::DEF_CORDIC_STEPS
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic [afr_pkg::FOV_W-1:0] i_fov_in,
    input wire logic                      o_strobe,
    input wire logic [afr_pkg::FOV_W-1:0] o_fov_out,
    input wire logic                      o_cfg_ready
);
    import afr_pkg::*;

    localparam int LAT = 2 * CORDIC_STEPS + 3;
    localparam int UW  = $clog2(LAT + 1);

    logic [UW-1:0] r_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up <= '0;
        end else if (r_up != UW'(LAT)) begin
            r_up <= r_up + UW'(1);
        end
    end

    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && o_cfg_ready)
        else $error("busy or cfg ready not as expected");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe raised straight after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up == UW'(LAT)) |-> (o_strobe == $past(start && !busy, LAT)))
        else $error("result strobe does not match beat latency");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up == UW'(LAT)) && o_strobe && ($past(i_fov_in, LAT) < FOV_180)
        |-> (o_fov_out <= FOV_180))
        else $error("result angle above 180 degrees");

endmodule

bind aspect_fov_rescale_unit afr_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_afr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_fov_in    (i_fov_in),
    .o_strobe    (o_strobe),
    .o_fov_out   (o_fov_out),
    .o_cfg_ready (o_cfg_ready)
);

`default_nettype wire
